// ===== rtl/core/plm_pkg.sv =====
`timescale 1ns / 1ps

package plm_pkg;

    // Field widths of the stream items
    localparam int POS_W     = 16;
    localparam int VAL_W     = 17;
    localparam int IDX_IN_W  = 4;
    localparam int CNT_IN_W  = 5;
    localparam int ENTRY_W   = POS_W + VAL_W;

    // Default table size
    localparam int DEFAULT_TABLE_DEPTH = 16;

    // Interpolation arithmetic
    localparam int DPOS_W    = POS_W + 1;
    localparam int DVAL_W    = VAL_W + 1;
    localparam int PROD_W    = DPOS_W + DVAL_W;
    localparam int QUO_W     = 18;
    localparam int QMAG_W    = QUO_W + 1;
    localparam int SUM_W     = QMAG_W + 1;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    localparam logic [POS_W-1:0]  Q_ONE        = 16'h8000;
    localparam logic [VAL_W-1:0]  VAL_MIN_BITS = 17'h10000;
    localparam logic [VAL_W-1:0]  VAL_MAX_BITS = 17'h0FFFF;
    localparam logic [QMAG_W-1:0] QUO_OVF      = 19'h40000;

    // Item kinds carried on tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEARCH,
        ST_NEXT,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } plm_state_t;

endpackage

// ===== rtl/core/plm_ram.sv =====
`timescale 1ns / 1ps

module plm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/piecewise_linear_mapper.sv =====
`timescale 1ns / 1ps

// Piecewise-linear mapper: a table of breakpoints (position, value) maps a
// query position to a linearly interpolated value.
// Input channel s_axis_*: tuser selects the kind of transaction. A load
// (tuser = 0) writes one table entry and produces no output. An evaluate
// (tuser = 1) produces exactly one output transaction on m_axis_*.
// cfg_we / cfg_wdata set the number of breakpoints in use; write it only
// while the block is idle.
// Sequence: an evaluate with n points in use (n >= 2) runs two passes over
// the table memory's single read port (min/max scan, then a downward
// search) and can end in an 18-step restoring divider; with fewer than
// two points the position passes through. The input is accepted only
// while the sequencer is idle; one item is in work at a time, and the
// next input is taken once the result has moved to the output register.
// The result sits in an output register: a stalled receiver does not hold
// up the next input, but a second result waits in the sequencer until the
// output register frees up.
// Reset clears the sequencer, the output valid and the point count; the
// table contents are not cleared and must be loaded before use.
module piecewise_linear_mapper #(
    parameter int TABLE_DEPTH = plm_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // config: number of breakpoints in use
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] point_index, [19:4] master_position, [36:20] point_value, zero pad
    input  logic [39:0] s_axis_tdata,
    // [0] func
    input  logic        s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [16:0] mapped_value, [20:17] segment_start, zero pad
    output logic [23:0] m_axis_tdata
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // ---------------------------------------------------------------
    // Input field unpacking
    // ---------------------------------------------------------------
    logic                           in_func;
    logic [plm_pkg::IDX_IN_W-1:0]   in_idx;
    logic [plm_pkg::POS_W-1:0]      in_pos;
    logic [plm_pkg::VAL_W-1:0]      in_val;

    assign in_func = s_axis_tuser;
    assign in_idx  = s_axis_tdata[3:0];
    assign in_pos  = s_axis_tdata[19:4];
    assign in_val  = s_axis_tdata[36:20];

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    plm_pkg::plm_state_t state_reg, state_next;

    logic [plm_pkg::CNT_IN_W-1:0] pts_reg;
    logic [CNT_W-1:0]             n_reg, n_next;
    logic [IDX_W-1:0]             addr_reg, addr_next;
    logic                         issued_all_reg, issued_all_next;
    logic                         pend_reg, pend_next;
    logic [IDX_W-1:0]             pend_idx_reg, pend_idx_next;
    logic                         m_valid_reg, m_valid_next;
    logic [plm_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [plm_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [plm_pkg::POS_W-1:0]         lo_reg, lo_next;
    logic [plm_pkg::POS_W-1:0]         hi_reg, hi_next;
    logic [plm_pkg::POS_W-1:0]         p0_reg, p0_next;
    logic [plm_pkg::VAL_W-1:0]         v0_reg, v0_next;
    logic [IDX_W-1:0]                  seg_reg, seg_next;
    logic signed [plm_pkg::DPOS_W-1:0] dpos_reg, dpos_next;
    logic signed [plm_pkg::DVAL_W-1:0] dv_reg, dv_next;
    logic [plm_pkg::POS_W-1:0]         d_reg, d_next;
    logic signed [plm_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                              neg_reg, neg_next;
    logic [plm_pkg::QUO_W-1:0]         num_reg, num_next;
    logic [plm_pkg::POS_W-1:0]         rem_reg, rem_next;
    logic [plm_pkg::QMAG_W-1:0]        q_reg, q_next;
    logic [plm_pkg::VAL_W-1:0]         res_reg, res_next;
    logic [plm_pkg::VAL_W-1:0]         out_val_reg, out_val_next;
    logic [plm_pkg::IDX_IN_W-1:0]      out_seg_reg, out_seg_next;

    // ---------------------------------------------------------------
    // Table memory: {value, position} per entry
    // ---------------------------------------------------------------
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [plm_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]              ram_raddr;
    logic [plm_pkg::ENTRY_W-1:0]   ram_rdata;
    logic [plm_pkg::POS_W-1:0]     rd_pos;
    logic [plm_pkg::VAL_W-1:0]     rd_val;

    plm_ram #(
        .WIDTH (plm_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_waddr = IDX_W'(in_idx);
    assign ram_wdata = {in_val, in_pos};
    assign rd_pos    = ram_rdata[plm_pkg::POS_W-1:0];
    assign rd_val    = ram_rdata[plm_pkg::ENTRY_W-1:plm_pkg::POS_W];

    // ---------------------------------------------------------------
    // Handshake and output
    // ---------------------------------------------------------------
    logic s_fire;
    logic [CNT_W-1:0] n_calc;
    logic [CNT_W-1:0] n_last;

    assign s_axis_tready = (state_reg == plm_pkg::ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, out_seg_reg, out_val_reg};

    // Cap the configured count at the table size
    assign n_calc = (32'(pts_reg) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(pts_reg);
    assign n_last = n_reg - CNT_W'(1);

    // ---------------------------------------------------------------
    // Sequencer: next state and datapath
    // ---------------------------------------------------------------
    logic [plm_pkg::POS_W-1:0]     lo_new, hi_new, clamp_lo;
    logic [plm_pkg::DPOS_W-1:0]    d_full;
    logic [plm_pkg::PROD_W-1:0]    mag;
    logic [plm_pkg::DPOS_W-1:0]    partial;
    logic [plm_pkg::DPOS_W:0]      trial;
    logic                          ge;
    logic [plm_pkg::SUM_W-1:0]     q_ext, q_sgn, sum;

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        addr_next       = addr_reg;
        issued_all_next = issued_all_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        div_cnt_next    = div_cnt_reg;
        pos_next        = pos_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        p0_next         = p0_reg;
        v0_next         = v0_reg;
        seg_next        = seg_reg;
        dpos_next       = dpos_reg;
        dv_next         = dv_reg;
        d_next          = d_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        res_next        = res_reg;
        out_val_next    = out_val_reg;
        out_seg_next    = out_seg_reg;
        ram_we          = 1'b0;
        ram_raddr       = addr_reg;

        lo_new   = (rd_pos < lo_reg) ? rd_pos : lo_reg;
        hi_new   = (rd_pos > hi_reg) ? rd_pos : hi_reg;
        clamp_lo = (pos_reg < lo_new) ? lo_new : pos_reg;
        d_full   = {1'b0, rd_pos} - {1'b0, p0_reg};
        mag      = prod_reg[plm_pkg::PROD_W-1] ? (plm_pkg::PROD_W'(0) - prod_reg)
                                               : prod_reg;
        partial  = {rem_reg, num_reg[plm_pkg::QUO_W-1]};
        trial    = {1'b0, partial} - {2'b00, d_reg};
        ge       = !trial[plm_pkg::DPOS_W];
        q_ext    = {1'b0, q_reg};
        q_sgn    = neg_reg ? (plm_pkg::SUM_W'(0) - q_ext) : q_ext;
        sum      = {{(plm_pkg::SUM_W - plm_pkg::VAL_W){v0_reg[plm_pkg::VAL_W-1]}}, v0_reg}
                   + q_sgn;

        case (state_reg)
            plm_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (in_func == plm_pkg::FUNC_LOAD)
                    begin
                        // drop loads beyond the table
                        ram_we = (32'(in_idx) < 32'(TABLE_DEPTH));
                    end
                    else
                    begin
                        n_next   = n_calc;
                        pos_next = in_pos;
                        if (n_calc < CNT_W'(2))
                        begin
                            // too few points: pass the position through
                            res_next   = {1'b0, in_pos};
                            seg_next   = '0;
                            state_next = plm_pkg::ST_DONE;
                        end
                        else
                        begin
                            lo_next         = plm_pkg::Q_ONE;
                            hi_next         = '0;
                            addr_next       = '0;
                            issued_all_next = 1'b0;
                            pend_next       = 1'b0;
                            state_next      = plm_pkg::ST_SCAN;
                        end
                    end
                end
            end

            plm_pkg::ST_SCAN:
            begin
                pend_next = 1'b0;
                if (!issued_all_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = addr_reg;
                    if (CNT_W'(addr_reg) == n_last)
                    begin
                        issued_all_next = 1'b1;
                    end
                    else
                    begin
                        addr_next = addr_reg + IDX_W'(1);
                    end
                end
                if (pend_reg)
                begin
                    lo_next = lo_new;
                    hi_next = hi_new;
                    if (CNT_W'(pend_idx_reg) == n_last)
                    begin
                        // raise to the low bound, then lower to the high bound
                        pos_next        = (clamp_lo > hi_new) ? hi_new : clamp_lo;
                        addr_next       = IDX_W'(n_last);
                        issued_all_next = 1'b0;
                        pend_next       = 1'b0;
                        state_next      = plm_pkg::ST_SEARCH;
                    end
                end
            end

            plm_pkg::ST_SEARCH:
            begin
                pend_next = 1'b0;
                if (!issued_all_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = addr_reg;
                    if (addr_reg == '0)
                    begin
                        issued_all_next = 1'b1;
                    end
                    else
                    begin
                        addr_next = addr_reg - IDX_W'(1);
                    end
                end
                if (pend_reg && !(rd_pos > pos_reg && pend_idx_reg != '0))
                begin
                    // stop at the first entry at or below, or at entry zero
                    seg_next  = pend_idx_reg;
                    p0_next   = rd_pos;
                    v0_next   = rd_val;
                    pend_next = 1'b0;
                    if (CNT_W'(pend_idx_reg) == n_last)
                    begin
                        res_next   = rd_val;
                        state_next = plm_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = plm_pkg::ST_NEXT;
                    end
                end
            end

            plm_pkg::ST_NEXT:
            begin
                ram_raddr = seg_reg + IDX_W'(1);
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    dpos_next = {1'b0, pos_reg} - {1'b0, p0_reg};
                    dv_next   = {rd_val[plm_pkg::VAL_W-1], rd_val}
                              - {v0_reg[plm_pkg::VAL_W-1], v0_reg};
                    d_next    = d_full[plm_pkg::POS_W-1:0];
                    if (!d_full[plm_pkg::DPOS_W-1] && d_full != '0)
                    begin
                        state_next = plm_pkg::ST_MUL;
                    end
                    else
                    begin
                        // empty or reversed interval: hold the lower value
                        res_next   = v0_reg;
                        state_next = plm_pkg::ST_DONE;
                    end
                end
            end

            plm_pkg::ST_MUL:
            begin
                prod_next  = dpos_reg * dv_reg;
                state_next = plm_pkg::ST_ABS;
            end

            plm_pkg::ST_ABS:
            begin
                neg_next = prod_reg[plm_pkg::PROD_W-1];
                if (mag[plm_pkg::PROD_W-1:plm_pkg::QUO_W] >= {1'b0, d_reg})
                begin
                    // quotient too large for 18 bits: the sum saturates anyway
                    q_next     = plm_pkg::QUO_OVF;
                    state_next = plm_pkg::ST_FIN;
                end
                else
                begin
                    rem_next     = mag[plm_pkg::QUO_W+plm_pkg::POS_W-1:plm_pkg::QUO_W];
                    num_next     = mag[plm_pkg::QUO_W-1:0];
                    q_next       = '0;
                    div_cnt_next = '0;
                    state_next   = plm_pkg::ST_DIV;
                end
            end

            plm_pkg::ST_DIV:
            begin
                // one restoring-division step per cycle
                rem_next     = ge ? trial[plm_pkg::POS_W-1:0] : partial[plm_pkg::POS_W-1:0];
                num_next     = {num_reg[plm_pkg::QUO_W-2:0], 1'b0};
                q_next       = {q_reg[plm_pkg::QMAG_W-2:0], ge};
                div_cnt_next = div_cnt_reg + plm_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == plm_pkg::DIV_CNT_W'(plm_pkg::QUO_W - 1))
                begin
                    state_next = plm_pkg::ST_FIN;
                end
            end

            plm_pkg::ST_FIN:
            begin
                if (sum[plm_pkg::SUM_W-1:plm_pkg::VAL_W-1] == '0
                    || sum[plm_pkg::SUM_W-1:plm_pkg::VAL_W-1] == '1)
                begin
                    res_next = sum[plm_pkg::VAL_W-1:0];
                end
                else
                begin
                    res_next = sum[plm_pkg::SUM_W-1] ? plm_pkg::VAL_MIN_BITS
                                                     : plm_pkg::VAL_MAX_BITS;
                end
                state_next = plm_pkg::ST_DONE;
            end

            plm_pkg::ST_DONE:
            begin
                // advance into the output register once it frees up
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_val_next = res_reg;
                    out_seg_next = plm_pkg::IDX_IN_W'(seg_reg);
                    m_valid_next = 1'b1;
                    state_next   = plm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = plm_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= plm_pkg::ST_IDLE;
            pts_reg        <= '0;
            n_reg          <= '0;
            addr_reg       <= '0;
            issued_all_reg <= 1'b0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            m_valid_reg    <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                pts_reg <= cfg_wdata;
            end
            n_reg          <= n_next;
            addr_reg       <= addr_next;
            issued_all_reg <= issued_all_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            m_valid_reg    <= m_valid_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        p0_reg      <= p0_next;
        v0_reg      <= v0_next;
        seg_reg     <= seg_next;
        dpos_reg    <= dpos_next;
        dv_reg      <= dv_next;
        d_reg       <= d_next;
        prod_reg    <= prod_next;
        neg_reg     <= neg_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        res_reg     <= res_next;
        out_val_reg <= out_val_next;
        out_seg_reg <= out_seg_next;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`ifndef NO_ASSERTIONS
    // A load never creates an output transaction
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && in_func == plm_pkg::FUNC_LOAD && !m_valid_reg) |=> !m_valid_reg)
        else $error("load produced an output transaction");

    // The divider remainder stays below the divisor
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plm_pkg::ST_DIV) |-> (rem_reg < d_reg))
        else $error("divider remainder out of range");

    // Interpolation only starts below the top point in use
    a_seg_below_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plm_pkg::ST_NEXT) |-> (CNT_W'(seg_reg) < n_last))
        else $error("interpolation from the top entry");

    // Divider runs exactly the quotient width
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plm_pkg::ST_DIV && state_next == plm_pkg::ST_FIN)
        |-> (div_cnt_reg == plm_pkg::DIV_CNT_W'(plm_pkg::QUO_W - 1)))
        else $error("divider left early");
`endif

endmodule

// ===== bench/mapping_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels and the count register, keeps its own copy of
// the breakpoint table and predicts every evaluation result.
module mapping_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          mismatches,
    output int          outstanding,
    output int          checked_results,
    output int          loads_seen,
    output int          evals_seen
);

    localparam int     DEPTH     = plm_pkg::DEFAULT_TABLE_DEPTH;
    localparam longint VAL_FLOOR = -(longint'(1) << (plm_pkg::VAL_W - 1));
    localparam longint VAL_CEIL  = (longint'(1) << (plm_pkg::VAL_W - 1)) - 1;

    typedef struct {
        logic signed [plm_pkg::VAL_W-1:0] value;
        logic [3:0]                       segment;
    } mapping_t;

    logic [plm_pkg::POS_W-1:0]        knot_pos [DEPTH];
    logic signed [plm_pkg::VAL_W-1:0] knot_val [DEPTH];
    logic [plm_pkg::CNT_IN_W-1:0]     point_count;
    mapping_t                         expected_mappings [$];

    function automatic logic signed [plm_pkg::VAL_W-1:0] saturate_value(longint v);
        if (v < VAL_FLOOR)
            v = VAL_FLOOR;
        else if (v > VAL_CEIL)
            v = VAL_CEIL;
        return v[plm_pkg::VAL_W-1:0];
    endfunction

    function automatic mapping_t map_position(logic [plm_pkg::POS_W-1:0] query);
        mapping_t r;
        int       used;
        int       seg;
        int       k;
        longint   lo;
        longint   hi;
        longint   p;
        longint   p0;
        longint   d;
        longint   dv;
        used = (point_count > DEPTH) ? DEPTH : int'(point_count);
        r.segment = '0;
        if (used < 2)
        begin
            r.value = saturate_value(longint'(query));
            return r;
        end
        // clamp: raise to the smaller of 1.0 and the lowest knot, then lower to
        // the larger of 0 and the highest knot
        lo = longint'(plm_pkg::Q_ONE);
        hi = 0;
        for (k = 0; k < used; k++)
        begin
            if (longint'(knot_pos[k]) < lo)
                lo = longint'(knot_pos[k]);
            if (longint'(knot_pos[k]) > hi)
                hi = longint'(knot_pos[k]);
        end
        p = longint'(query);
        if (p < lo)
            p = lo;
        if (p > hi)
            p = hi;
        seg = used - 1;
        while (seg > 0 && longint'(knot_pos[seg]) > p)
            seg--;
        r.segment = 4'(seg);
        if (seg == used - 1)
        begin
            r.value = saturate_value(longint'(knot_val[seg]));
            return r;
        end
        p0 = longint'(knot_pos[seg]);
        d  = longint'(knot_pos[seg + 1]) - p0;
        if (d > 0)
        begin
            dv = longint'(knot_val[seg + 1]) - longint'(knot_val[seg]);
            r.value = saturate_value(longint'(knot_val[seg]) + ((p - p0) * dv) / d);
        end
        else
            r.value = saturate_value(longint'(knot_val[seg]));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        mapping_t         want;
        mapping_t         got;
        logic [3:0]       idx;
        if (!rst_n)
        begin
            point_count = '0;
            expected_mappings.delete();
            mismatches = 0;
            outstanding = 0;
            checked_results = 0;
            loads_seen = 0;
            evals_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.value   = m_tdata[plm_pkg::VAL_W-1:0];
                got.segment = m_tdata[plm_pkg::VAL_W +: 4];
                if (expected_mappings.size() == 0)
                begin
                    $error("unexpected result: mapped_value %0d, segment_start %0d",
                           got.value, got.segment);
                    mismatches++;
                end
                else
                begin
                    want = expected_mappings.pop_front();
                    checked_results++;
                    if (got.value !== want.value)
                    begin
                        $error("mapped_value: expected %0d, actual %0d", want.value, got.value);
                        mismatches++;
                    end
                    if (got.segment !== want.segment)
                    begin
                        $error("segment_start: expected %0d, actual %0d",
                               want.segment, got.segment);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
                point_count = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == plm_pkg::FUNC_LOAD)
                begin
                    idx = s_tdata[plm_pkg::IDX_IN_W-1:0];
                    knot_pos[idx] = s_tdata[plm_pkg::IDX_IN_W +: plm_pkg::POS_W];
                    knot_val[idx] = s_tdata[plm_pkg::IDX_IN_W + plm_pkg::POS_W +: plm_pkg::VAL_W];
                    loads_seen++;
                end
                else
                begin
                    expected_mappings.push_back(
                        map_position(s_tdata[plm_pkg::IDX_IN_W +: plm_pkg::POS_W]));
                    evals_seen++;
                end
            end
            outstanding = expected_mappings.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the piecewise-linear mapper. The mapping_checker
// beside the block does all prediction and comparison; this module only
// drives traffic, paces the output side and reports the outcome.
module testbench;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int ITEM_TARGET   = 750;
    // leave room for an evaluation still in work before touching the count
    localparam int SETTLE_CYCLES = 80;
    localparam int LONG_HOLD     = 800;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DEPTH         = plm_pkg::DEFAULT_TABLE_DEPTH;

    typedef enum int {
        SHAPE_SPREAD,
        SHAPE_NARROW,
        SHAPE_REPEAT,
        SHAPE_SHUFFLED,
        SHAPE_WILD
    } table_shape_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [3:0] point_index, [19:4] master_position, [36:20] point_value, zero pad
    logic [39:0] s_axis_tdata;
    // [0] func
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [16:0] mapped_value, [20:17] segment_start, zero pad
    logic [23:0] m_axis_tdata;

    int mismatches;
    int outstanding;
    int checked_results;
    int loads_seen;
    int evals_seen;

    int cycle_count    = 0;
    int burst_left     = 0;
    int items_sent     = 0;
    int settings_used  = 0;
    int active_count   = 0;
    int hold_requests  = 0;
    int holds_done     = 0;
    logic [plm_pkg::POS_W-1:0] loaded_pos [DEPTH];

    piecewise_linear_mapper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mapping_checker mapping_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_axis_tvalid),
        .s_tready        (s_axis_tready),
        .s_tdata         (s_axis_tdata),
        .s_tuser         (s_axis_tuser),
        .m_tvalid        (m_axis_tvalid),
        .m_tready        (m_axis_tready),
        .m_tdata         (m_axis_tdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .checked_results (checked_results),
        .loads_seen      (loads_seen),
        .evals_seen      (evals_seen)
    );

    always #(CLK_HALF) clk = ~clk;

    // Watchdog: abort a run that hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** piecewise_linear_mapper: FAILED **");
            $finish;
        end
    end

    // Offer one transaction and hold it until the block takes it. The sender
    // works in bursts; between bursts it often drops tvalid for a random gap.
    task automatic send_item(logic func, logic [3:0] idx, logic [plm_pkg::POS_W-1:0] pos,
                             logic [plm_pkg::VAL_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, val, pos, idx};
        s_axis_tuser  <= func;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (func == plm_pkg::FUNC_LOAD)
            loaded_pos[idx] = pos;
        items_sent++;
    endtask

    // Change the point count only once the block has drained: wait for every
    // predicted result, then let a load or evaluation still in work finish.
    task automatic write_point_count(logic [4:0] count);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
        active_count = (count > DEPTH) ? DEPTH : int'(count);
        settings_used++;
    endtask

    // Output side: stretches of free flow, light and heavy random stalls and a
    // toggling pattern. On request, hold off for a long stretch so the result
    // register and the sequencer both fill and the input stalls.
    initial
    begin : output_sink
        int mode;
        int span;
        int tick;
        forever
        begin
            if (holds_done != hold_requests)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 60);
                for (tick = 0; tick < span; tick++)
                begin
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                        2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
                        default: m_axis_tready <= tick[0];
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int                        n;
        int                        used;
        int                        queries;
        int                        phase;
        int                        k;
        int                        j;
        int                        lo_b;
        int                        hi_b;
        int                        pick;
        int                        near;
        table_shape_t              shape;
        logic [plm_pkg::POS_W-1:0] pos_list [DEPTH];
        logic [plm_pkg::POS_W-1:0] swap_pos;
        logic [plm_pkg::POS_W-1:0] qpos;
        logic [plm_pkg::VAL_W-1:0] val;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = plm_pkg::FUNC_LOAD;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fewer than two points: the position passes through unclamped.
        write_point_count(5'd0);
        send_item(plm_pkg::FUNC_EVAL, 4'hF, plm_pkg::Q_ONE, 17'h1FFFF);
        write_point_count(5'd1);
        send_item(plm_pkg::FUNC_EVAL, 4'h0, 16'h0000, '0);

        // Full table with alternating extreme values: steep rising and falling
        // segments, last knot exactly at 1.0.
        for (k = 0; k < DEPTH; k++)
            send_item(plm_pkg::FUNC_LOAD, k[3:0],
                      (k == DEPTH - 1) ? plm_pkg::Q_ONE : 16'(k * 2048),
                      k[0] ? plm_pkg::VAL_MAX_BITS : plm_pkg::VAL_MIN_BITS);
        write_point_count(5'd16);
        send_item(plm_pkg::FUNC_EVAL, 4'h0, 16'd0, '0);
        send_item(plm_pkg::FUNC_EVAL, 4'h0, 16'd1023, '0);
        send_item(plm_pkg::FUNC_EVAL, 4'h0, 16'd3073, '0);   // falling: truncate toward zero
        send_item(plm_pkg::FUNC_EVAL, 4'h0, plm_pkg::Q_ONE, '0);  // top knot returns its value

        // Knots above 1.0: the search finds nothing at or below the clamped
        // position and extrapolates from entry 0, saturating; then a
        // zero-width interval.
        send_item(plm_pkg::FUNC_LOAD, 4'd0, 16'd33000, 17'd65000);
        send_item(plm_pkg::FUNC_LOAD, 4'd1, 16'd40000, plm_pkg::VAL_MIN_BITS);
        write_point_count(5'd2);
        send_item(plm_pkg::FUNC_EVAL, 4'h0, 16'd0, '0);
        send_item(plm_pkg::FUNC_LOAD, 4'd1, 16'd33000, 17'd777);
        send_item(plm_pkg::FUNC_EVAL, 4'h0, 16'd0, '0);

        // Random phases: load a fresh table (mostly sorted), set the count,
        // then query with stray loads mixed in.
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            phase++;
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(0, 1);
                1:       n = 2;
                2, 3:    n = DEPTH;
                4:       n = $urandom_range(DEPTH + 1, 31);
                default: n = $urandom_range(3, DEPTH - 1);
            endcase
            if (phase == 1)
                n = 31;         // oversized count acts as a full table
            if (phase == 2)
                n = DEPTH;
            used = (n > DEPTH) ? DEPTH : n;

            case ($urandom_range(0, 9))
                0, 1, 2, 3: shape = SHAPE_SPREAD;
                4, 5:       shape = SHAPE_NARROW;
                6, 7:       shape = SHAPE_REPEAT;
                8:          shape = SHAPE_SHUFFLED;
                default:    shape = SHAPE_WILD;
            endcase
            lo_b = 0;
            hi_b = plm_pkg::Q_ONE;
            if (shape == SHAPE_NARROW)
            begin
                lo_b = $urandom_range(1, 16000);
                hi_b = $urandom_range(lo_b, 32767);
            end
            if (shape == SHAPE_WILD)
                hi_b = 65535;

            // build an ascending list by insertion
            for (k = 0; k < used; k++)
            begin
                pos_list[k] = 16'($urandom_range(lo_b, hi_b));
                for (j = k; j > 0 && pos_list[j - 1] > pos_list[j]; j--)
                begin
                    swap_pos        = pos_list[j];
                    pos_list[j]     = pos_list[j - 1];
                    pos_list[j - 1] = swap_pos;
                end
            end
            if (used >= 2)
            begin
                if (shape == SHAPE_SPREAD && $urandom_range(0, 1) == 1)
                begin
                    pos_list[0]        = 16'd0;
                    pos_list[used - 1] = plm_pkg::Q_ONE;
                end
                if (shape == SHAPE_REPEAT)
                    for (k = 1; k < used; k++)
                        if ($urandom_range(0, 2) == 0)
                            pos_list[k] = pos_list[k - 1];
                if (shape == SHAPE_SHUFFLED || shape == SHAPE_WILD)
                    for (k = 0; k < used; k++)
                    begin
                        j = $urandom_range(0, used - 1);
                        swap_pos    = pos_list[k];
                        pos_list[k] = pos_list[j];
                        pos_list[j] = swap_pos;
                    end
                for (k = 0; k < used; k++)
                begin
                    val = ($urandom_range(0, 7) == 0)
                          ? (k[0] ? plm_pkg::VAL_MAX_BITS : plm_pkg::VAL_MIN_BITS)
                          : 17'($urandom);
                    send_item(plm_pkg::FUNC_LOAD, k[3:0], pos_list[k], val);
                end
            end
            write_point_count(5'(n));

            queries = $urandom_range(10, 40);
            if (phase == 2)
            begin
                // keep offering items while the output side holds off
                hold_requests++;
                queries = 40;
            end

            for (j = 0; j < queries; j++)
            begin
                pick = $urandom_range(0, 19);
                k = (active_count >= 2) ? $urandom_range(0, active_count - 1)
                                        : $urandom_range(0, DEPTH - 1);
                if (pick == 0)
                begin
                    // stray load: rewrite a random entry mid-phase
                    send_item(plm_pkg::FUNC_LOAD, 4'($urandom),
                              16'($urandom_range(0, plm_pkg::Q_ONE)), 17'($urandom));
                end
                else
                begin
                    if (pick <= 2)
                        qpos = 16'd0;
                    else if (pick <= 4)
                        qpos = plm_pkg::Q_ONE;
                    else if (pick <= 9)
                        qpos = loaded_pos[k];
                    else if (pick <= 12)
                    begin
                        near = int'(loaded_pos[k]) + $urandom_range(0, 6) - 3;
                        if (near < 0)
                            near = 0;
                        if (near > 65535)
                            near = 65535;
                        qpos = 16'(near);
                    end
                    else
                        qpos = 16'($urandom_range(0, plm_pkg::Q_ONE));
                    send_item(plm_pkg::FUNC_EVAL, 4'($urandom), qpos, 17'($urandom));
                end
            end
        end

        // Drain: wait for every predicted result, then watch for strays.
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Coverage: %0d loads, %0d evaluations, %0d results compared, %0d count settings.",
                 loads_seen, evals_seen, checked_results, settings_used);
        $display("Tables ranged over pass-through, clamped, repeated, unsorted and above-1.0 knots.");
        if (mismatches == 0)
            $display("** piecewise_linear_mapper: PASSED **");
        else
            $display("** piecewise_linear_mapper: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/plm_pkg.sv
rtl/core/plm_ram.sv
rtl/core/piecewise_linear_mapper.sv
bench/mapping_checker.sv
bench/testbench.sv
